// ===== design/assert_macros.svh =====
// Assertion macros shared by the mixer RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/svbm_pkg.sv =====
// Shared constants, register codes and payload types of the stereo mixer.
// No dependencies; every design module refers to it by scoped names.
package svbm_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned BAL_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned MAG_W   = 23;
  localparam int unsigned QUO_W   = 16;
  localparam int unsigned DEN_W   = 8;
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned FRAME_W = 32;

  // Percent scale and the reciprocal used for the divide by one hundred.
  localparam int unsigned PCT_FULL    = 100;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'((1 << RECIP_SHIFT) / PCT_FULL);

  // Register limits and reset values.
  localparam logic [VOL_W-1:0]         VOL_FULL  = VOL_W'(PCT_FULL);
  localparam logic signed [BAL_W-1:0]  BAL_MAX   = 8'sd100;
  localparam logic signed [BAL_W-1:0]  BAL_MIN   = -8'sd100;
  localparam logic signed [BAL_W-1:0]  BAL_ZERO  = 8'sd0;
  localparam logic [COEF_W-1:0]        COEF_FULL = COEF_W'(PCT_FULL);
  localparam logic [COEF_W-1:0]        COEF_NONE = '0;
  localparam logic [DEN_W-1:0]         DEN_FULL  = DEN_W'(PCT_FULL);

  // Stage counts of the pipelined dividers and their lane count.
  localparam int unsigned PCT_NST  = 4;
  localparam int unsigned LDIV_NST = 1 + QUO_W;
  localparam int unsigned LANES    = 2;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_VOLUME  = 2'd0,
    REG_BALANCE = 2'd1,
    REG_MONO    = 2'd2
  } cfg_reg_t;

  // Input frame.
  typedef struct packed {
    logic signed [SAMP_W-1:0] left_sample;
    logic signed [SAMP_W-1:0] right_sample;
  } in_frame_t;

  // Result frame.
  typedef struct packed {
    logic signed [SAMP_W-1:0] left_out;
    logic signed [SAMP_W-1:0] right_out;
    logic [FRAME_W-1:0]       packed_frame;
  } out_frame_t;

  // Volume-scaled products before the divide by one hundred.
  typedef struct packed {
    logic signed [NUM_W-1:0] left;
    logic signed [NUM_W-1:0] right;
  } num_pair_t;

  // Volume-scaled samples.
  typedef struct packed {
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
  } samp_pair_t;

  // Balance weights and divisors, derived from the balance register.
  typedef struct packed {
    logic [COEF_W-1:0] self_l;
    logic [COEF_W-1:0] cross_l;
    logic [DEN_W-1:0]  den_l;
    logic [COEF_W-1:0] self_r;
    logic [COEF_W-1:0] cross_r;
    logic [DEN_W-1:0]  den_r;
  } mix_coef_t;

  // Dividend and divisor pairs into the long divider.
  typedef struct packed {
    num_pair_t         num;
    logic [DEN_W-1:0]  den_l;
    logic [DEN_W-1:0]  den_r;
  } div_in_t;

  // One lane of the long divider as it moves from stage to stage.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
  } ldiv_lane_t;

  // Sign and magnitude of a final quotient.
  typedef struct packed {
    logic [QUO_W-1:0] mag;
    logic             neg;
  } quot_t;

  typedef struct packed {
    quot_t left;
    quot_t right;
  } quot_pair_t;

endpackage

// ===== design/svbm_scale.sv =====
// Input stage: mono selection and multiply of both samples by the volume.
// Depends on svbm_pkg.
module svbm_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  svbm_pkg::in_frame_t   up_data,
  input  logic [svbm_pkg::VOL_W-1:0] vol,
  input  logic                  mono,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output svbm_pkg::num_pair_t   dn_data
);

  logic                  v_r;
  logic                  adv;
  svbm_pkg::num_pair_t   d_r;
  svbm_pkg::num_pair_t   d_nxt;
  logic signed [svbm_pkg::SAMP_W-1:0] smp_l;
  logic signed [svbm_pkg::SAMP_W-1:0] smp_r;

  // The stage loads when it is empty or its content moves on.
  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // In mono mode the left sample feeds both channels.
  always_comb begin
    smp_l       = up_data.left_sample;
    smp_r       = mono ? up_data.left_sample : up_data.right_sample;
    d_nxt.left  = svbm_pkg::NUM_W'(smp_l) * svbm_pkg::NUM_W'($signed({1'b0, vol}));
    d_nxt.right = svbm_pkg::NUM_W'(smp_r) * svbm_pkg::NUM_W'($signed({1'b0, vol}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== design/svbm_pctdiv.sv =====
// Four-stage divide by one hundred of both channels, truncating toward zero.
// Uses a reciprocal multiply with a one-step correction. Depends on svbm_pkg.
module svbm_pctdiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  svbm_pkg::num_pair_t   up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output svbm_pkg::samp_pair_t  dn_data
);

  localparam int unsigned NST = svbm_pkg::PCT_NST;
  localparam int unsigned LN  = svbm_pkg::LANES;

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST:0]   adv;

  // Stage registers, one entry per channel.
  logic [svbm_pkg::MAG_W-1:0]  a_mag_r  [LN];
  logic                        a_neg_r  [LN];
  logic [svbm_pkg::PROD_W-1:0] b_prod_r [LN];
  logic [svbm_pkg::MAG_W-1:0]  b_mag_r  [LN];
  logic                        b_neg_r  [LN];
  logic [svbm_pkg::QUO_W-1:0]  c_quo_r  [LN];
  logic                        c_ge_r   [LN];
  logic                        c_neg_r  [LN];
  logic [svbm_pkg::QUO_W-1:0]  d_res_r  [LN];

  // Next values.
  logic signed [svbm_pkg::NUM_W-1:0] num [LN];
  logic [svbm_pkg::MAG_W-1:0]  mag_nxt  [LN];
  logic [svbm_pkg::PROD_W-1:0] prod_nxt [LN];
  logic [svbm_pkg::QUO_W-1:0]  qest     [LN];
  logic [svbm_pkg::MAG_W-1:0]  rem      [LN];
  logic                        ge_nxt   [LN];
  logic [svbm_pkg::QUO_W-1:0]  quo_inc  [LN];
  logic [svbm_pkg::QUO_W-1:0]  res_nxt  [LN];

  // Ready ripples back: a stage loads when empty or when the next one loads.
  assign adv[NST] = dn_ready;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  assign v_in     = {v_r[NST-2:0], up_valid};
  assign up_ready = adv[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data.left  = d_res_r[0];
  assign dn_data.right = d_res_r[1];

  // Per channel: magnitude, reciprocal product, estimate and remainder, sign.
  always_comb begin
    num[0] = up_data.left;
    num[1] = up_data.right;
    for (int j = 0; j < LN; j++) begin
      mag_nxt[j]  = num[j][svbm_pkg::NUM_W-1] ? svbm_pkg::MAG_W'(-num[j])
                                              : svbm_pkg::MAG_W'(num[j]);
      prod_nxt[j] = svbm_pkg::PROD_W'(a_mag_r[j]) * svbm_pkg::PROD_W'(svbm_pkg::PCT_RECIP);
      qest[j]     = b_prod_r[j][svbm_pkg::RECIP_SHIFT +: svbm_pkg::QUO_W];
      rem[j]      = b_mag_r[j] - svbm_pkg::MAG_W'(qest[j]) * svbm_pkg::MAG_W'(svbm_pkg::PCT_FULL);
      ge_nxt[j]   = rem[j] >= svbm_pkg::MAG_W'(svbm_pkg::PCT_FULL);
      quo_inc[j]  = c_quo_r[j] + svbm_pkg::QUO_W'(c_ge_r[j]);
      res_nxt[j]  = c_neg_r[j] ? -quo_inc[j] : quo_inc[j];
    end
  end

  // Valid bits follow the data through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~adv[NST-1:0]) | (v_in & adv[NST-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LN; j++) begin
      if (adv[0]) begin
        a_mag_r[j] <= mag_nxt[j];
        a_neg_r[j] <= num[j][svbm_pkg::NUM_W-1];
      end
      if (adv[1]) begin
        b_prod_r[j] <= prod_nxt[j];
        b_mag_r[j]  <= a_mag_r[j];
        b_neg_r[j]  <= a_neg_r[j];
      end
      if (adv[2]) begin
        c_quo_r[j] <= qest[j];
        c_ge_r[j]  <= ge_nxt[j];
        c_neg_r[j] <= b_neg_r[j];
      end
      if (adv[3]) begin
        d_res_r[j] <= res_nxt[j];
      end
    end
  end

endmodule

// ===== design/svbm_mix.sv =====
// Balance stage: forms the weighted sums that the long divider divides.
// Depends on svbm_pkg.
module svbm_mix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  svbm_pkg::samp_pair_t  up_data,
  input  svbm_pkg::mix_coef_t   coef,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output svbm_pkg::div_in_t     dn_data
);

  logic                 v_r;
  logic                 adv;
  svbm_pkg::div_in_t    d_r;
  svbm_pkg::div_in_t    d_nxt;
  logic signed [svbm_pkg::NUM_W:0] pl_self;
  logic signed [svbm_pkg::NUM_W:0] pl_cross;
  logic signed [svbm_pkg::NUM_W:0] pr_self;
  logic signed [svbm_pkg::NUM_W:0] pr_cross;

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // Each channel keeps a share of itself and takes a share of the other.
  always_comb begin
    pl_self  = (svbm_pkg::NUM_W+1)'(up_data.left)
             * (svbm_pkg::NUM_W+1)'($signed({1'b0, coef.self_l}));
    pl_cross = (svbm_pkg::NUM_W+1)'(up_data.right)
             * (svbm_pkg::NUM_W+1)'($signed({1'b0, coef.cross_l}));
    pr_self  = (svbm_pkg::NUM_W+1)'(up_data.right)
             * (svbm_pkg::NUM_W+1)'($signed({1'b0, coef.self_r}));
    pr_cross = (svbm_pkg::NUM_W+1)'(up_data.left)
             * (svbm_pkg::NUM_W+1)'($signed({1'b0, coef.cross_r}));
    d_nxt.num.left  = svbm_pkg::NUM_W'(pl_self + pl_cross);
    d_nxt.num.right = svbm_pkg::NUM_W'(pr_self + pr_cross);
    d_nxt.den_l     = coef.den_l;
    d_nxt.den_r     = coef.den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== design/svbm_ldiv.sv =====
// Pipelined restoring divider for both channels: one sign stage, then one
// quotient bit per stage. Quotients fit in 16 bits. Depends on svbm_pkg.
module svbm_ldiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  svbm_pkg::div_in_t     up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output svbm_pkg::quot_pair_t  dn_data
);

  localparam int unsigned NST = svbm_pkg::LDIV_NST;
  localparam int unsigned LN  = svbm_pkg::LANES;

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST:0]   adv;

  svbm_pkg::ldiv_lane_t st_r   [NST][LN];
  svbm_pkg::ldiv_lane_t st_nxt [NST][LN];

  logic signed [svbm_pkg::NUM_W-1:0] num [LN];
  logic [svbm_pkg::DEN_W-1:0]        den [LN];

  assign adv[NST] = dn_ready;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  assign v_in     = {v_r[NST-2:0], up_valid};
  assign up_ready = adv[0];
  assign dn_valid = v_r[NST-1];
  assign dn_data.left.mag  = st_r[NST-1][0].quo;
  assign dn_data.left.neg  = st_r[NST-1][0].neg;
  assign dn_data.right.mag = st_r[NST-1][1].quo;
  assign dn_data.right.neg = st_r[NST-1][1].neg;

  always_comb begin
    logic [svbm_pkg::MAG_W-1:0] trial;
    logic                       ge;
    trial  = '0;
    ge     = 1'b0;
    num[0] = up_data.num.left;
    num[1] = up_data.num.right;
    den[0] = up_data.den_l;
    den[1] = up_data.den_r;
    // First stage splits sign and magnitude.
    for (int j = 0; j < LN; j++) begin
      st_nxt[0][j].rem = num[j][svbm_pkg::NUM_W-1] ? svbm_pkg::MAG_W'(-num[j])
                                                   : svbm_pkg::MAG_W'(num[j]);
      st_nxt[0][j].quo = '0;
      st_nxt[0][j].den = den[j];
      st_nxt[0][j].neg = num[j][svbm_pkg::NUM_W-1];
    end
    // Each later stage tries the divisor at one bit weight, high to low.
    for (int k = 1; k < NST; k++) begin
      for (int j = 0; j < LN; j++) begin
        trial        = svbm_pkg::MAG_W'(st_r[k-1][j].den) << (svbm_pkg::QUO_W - k);
        ge           = st_r[k-1][j].rem >= trial;
        st_nxt[k][j] = st_r[k-1][j];
        if (ge) begin
          st_nxt[k][j].rem = st_r[k-1][j].rem - trial;
          st_nxt[k][j].quo[svbm_pkg::QUO_W - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~adv[NST-1:0]) | (v_in & adv[NST-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      for (int j = 0; j < LN; j++) begin
        if (adv[k]) begin
          st_r[k][j] <= st_nxt[k][j];
        end
      end
    end
  end

endmodule

// ===== design/stereo_volume_balance_mixer_top.sv =====
// Stereo volume and balance mixer, top level; uses svbm_pkg and the svbm_* stages.
// Pipeline: scale, divide by 100, mix, long divider and output register, in that order;
// the 16 quotient stages of the balance divider set most of the depth.
// Throughput: one frame per cycle; stalls hold every stage and bubbles fill up.
// Reset (synchronous, active low) clears all valid bits and sets volume 100, balance 0, stereo.
`include "assert_macros.svh"

module stereo_volume_balance_mixer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  svbm_pkg::in_frame_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output svbm_pkg::out_frame_t          out_data,
  input  logic                          cfg_we,
  input  logic [svbm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [svbm_pkg::CFG_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic [svbm_pkg::VOL_W-1:0]        vol_r, vol_nxt;
  logic signed [svbm_pkg::BAL_W-1:0] bal_r, bal_nxt;
  logic                              mono_r, mono_nxt;

  svbm_pkg::mix_coef_t  coef;
  logic [svbm_pkg::COEF_W-1:0] bal_mag;

  // Links between stages.
  logic                  sc_valid, sc_ready;
  svbm_pkg::num_pair_t   sc_data;
  logic                  pd_valid, pd_ready;
  svbm_pkg::samp_pair_t  pd_data;
  logic                  mx_valid, mx_ready;
  svbm_pkg::div_in_t     mx_data;
  logic                  dv_valid, dv_ready;
  svbm_pkg::quot_pair_t  dv_data;

  // Output register.
  logic                  out_valid_r;
  svbm_pkg::out_frame_t  out_data_r, out_nxt;
  logic                  adv_out;
  logic [svbm_pkg::SAMP_W-1:0] res_l, res_r;

  // Register writes, with volume and balance saturated to their ranges.
  always_comb begin
    logic [svbm_pkg::VOL_W-1:0]        wvol;
    logic signed [svbm_pkg::BAL_W-1:0] wbal;
    wvol     = cfg_wdata[svbm_pkg::VOL_W-1:0];
    wbal     = $signed(cfg_wdata[svbm_pkg::BAL_W-1:0]);
    vol_nxt  = vol_r;
    bal_nxt  = bal_r;
    mono_nxt = mono_r;
    if (cfg_we) begin
      case (svbm_pkg::cfg_reg_t'(cfg_index))
        svbm_pkg::REG_VOLUME: begin
          vol_nxt = (wvol > svbm_pkg::VOL_FULL) ? svbm_pkg::VOL_FULL : wvol;
        end
        svbm_pkg::REG_BALANCE: begin
          if (wbal > svbm_pkg::BAL_MAX) begin
            bal_nxt = svbm_pkg::BAL_MAX;
          end else if (wbal < svbm_pkg::BAL_MIN) begin
            bal_nxt = svbm_pkg::BAL_MIN;
          end else begin
            bal_nxt = wbal;
          end
        end
        svbm_pkg::REG_MONO: begin
          mono_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r  <= svbm_pkg::VOL_FULL;
      bal_r  <= svbm_pkg::BAL_ZERO;
      mono_r <= 1'b0;
    end else begin
      vol_r  <= vol_nxt;
      bal_r  <= bal_nxt;
      mono_r <= mono_nxt;
    end
  end

  // Balance weights. A positive balance fades the left channel and blends it
  // into the right; a negative balance mirrors that. Centered balance divides by 100.
  always_comb begin
    bal_mag = bal_r[svbm_pkg::BAL_W-1] ? svbm_pkg::COEF_W'(-bal_r) : svbm_pkg::COEF_W'(bal_r);
    coef.self_l  = svbm_pkg::COEF_FULL;
    coef.cross_l = svbm_pkg::COEF_NONE;
    coef.den_l   = svbm_pkg::DEN_FULL;
    coef.self_r  = svbm_pkg::COEF_FULL;
    coef.cross_r = svbm_pkg::COEF_NONE;
    coef.den_r   = svbm_pkg::DEN_FULL;
    if (bal_r > svbm_pkg::BAL_ZERO) begin
      coef.self_l  = svbm_pkg::COEF_FULL - bal_mag;
      coef.cross_r = bal_mag;
      coef.den_r   = svbm_pkg::DEN_FULL + bal_mag;
    end else if (bal_r < svbm_pkg::BAL_ZERO) begin
      coef.cross_l = svbm_pkg::COEF_FULL - bal_mag;
      coef.den_l   = svbm_pkg::DEN_FULL + bal_mag;
      coef.self_r  = svbm_pkg::COEF_FULL - bal_mag;
    end
  end

  svbm_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .vol      (vol_r),
    .mono     (mono_r),
    .dn_valid (sc_valid),
    .dn_ready (sc_ready),
    .dn_data  (sc_data)
  );

  svbm_pctdiv u_pctdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sc_valid),
    .up_ready (sc_ready),
    .up_data  (sc_data),
    .dn_valid (pd_valid),
    .dn_ready (pd_ready),
    .dn_data  (pd_data)
  );

  svbm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pd_valid),
    .up_ready (pd_ready),
    .up_data  (pd_data),
    .coef     (coef),
    .dn_valid (mx_valid),
    .dn_ready (mx_ready),
    .dn_data  (mx_data)
  );

  svbm_ldiv u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mx_valid),
    .up_ready (mx_ready),
    .up_data  (mx_data),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_data  (dv_data)
  );

  // Output register: restore the signs and pack right over left.
  assign adv_out  = !out_valid_r || out_ready;
  assign dv_ready = adv_out;

  always_comb begin
    res_l = dv_data.left.neg  ? -dv_data.left.mag  : dv_data.left.mag;
    res_r = dv_data.right.neg ? -dv_data.right.mag : dv_data.right.mag;
    out_nxt.left_out     = res_l;
    out_nxt.right_out    = res_r;
    out_nxt.packed_frame = {res_r, res_l};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A write to the balance register always leaves it within plus or minus 100.
  `SVBM_ASSERT_NXT(a_bal_sat, cfg_we && (cfg_index == svbm_pkg::REG_BALANCE), (bal_r <= svbm_pkg::BAL_MAX) && (bal_r >= svbm_pkg::BAL_MIN), "balance register out of range after write")
  // A write to the volume register never leaves it above full scale.
  `SVBM_ASSERT_NXT(a_vol_sat, cfg_we && (cfg_index == svbm_pkg::REG_VOLUME), vol_r <= svbm_pkg::VOL_FULL, "volume register above full scale after write")
  // No result appears unless the divider offered one.
  `SVBM_ASSERT_NXT(a_no_phantom, adv_out && !dv_valid, !out_valid, "result appeared without a frame from the divider")
  // With the output register empty, the whole ready chain is open.
  `SVBM_ASSERT_IMP(a_ready_open, !out_valid, in_ready, "input not ready while output register is empty")

endmodule

// ===== bench/stereo_volume_balance_mixer_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stereo_volume_balance_mixer_top: directed and random frames are
// checked against a behavioral volume and balance mix under bursts and back-pressure.
// Depends on svbm_pkg and the mixer RTL.

module stereo_volume_balance_mixer_top_tb;

  localparam int PCT_SCALE   = 100;
  localparam int SETTLE_CYC  = 40;    // comfortably past the pipeline latency
  localparam int STALL_LIMIT = 1000;  // cycles with no transfer before giving up
  localparam int DIR_PHASES  = 8;
  localparam int DIR_RAND    = 10;
  localparam int RAND_PHASES = 16;
  localparam int RAND_ITEMS  = 98;
  localparam logic [svbm_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  svbm_pkg::in_frame_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  svbm_pkg::out_frame_t out_data;
  logic cfg_we = 1'b0;
  logic [svbm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [svbm_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Bench copy of the mixer registers.
  int mix_volume = PCT_SCALE;
  int mix_balance = 0;
  bit mix_mono = 1'b0;

  svbm_pkg::in_frame_t  pending_frames[$];
  svbm_pkg::out_frame_t expected_mixes[$];

  int error_count = 0;
  int mixes_checked = 0;
  int reg_writes = 0;
  int settings_done = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  always #5 clk = ~clk;

  stereo_volume_balance_mixer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Volume scaling, then the balance blend; C-style truncating divides on int.
  function automatic svbm_pkg::out_frame_t mix_frame(svbm_pkg::in_frame_t f);
    int l;
    int r;
    int yl;
    int yr;
    svbm_pkg::out_frame_t o;
    l = $signed(f.left_sample);
    r = mix_mono ? l : $signed(f.right_sample);
    l = (l * mix_volume) / PCT_SCALE;
    r = (r * mix_volume) / PCT_SCALE;
    if (mix_balance > 0) begin
      yl = (l * (PCT_SCALE - mix_balance)) / PCT_SCALE;
      yr = (r * PCT_SCALE + l * mix_balance) / (PCT_SCALE + mix_balance);
      l = yl;
      r = yr;
    end else if (mix_balance < 0) begin
      yl = (l * PCT_SCALE + r * (PCT_SCALE + mix_balance)) / (PCT_SCALE - mix_balance);
      yr = (r * (PCT_SCALE + mix_balance)) / PCT_SCALE;
      l = yl;
      r = yr;
    end
    o.left_out     = l[15:0];
    o.right_out    = r[15:0];
    o.packed_frame = {r[15:0], l[15:0]};
    return o;
  endfunction

  // Register decode with the saturation of out-of-range volume and balance.
  function automatic void model_write(logic [svbm_pkg::IDX_W-1:0] idx,
                                      logic [svbm_pkg::CFG_W-1:0] data);
    int v;
    v = 0;
    case (idx)
      svbm_pkg::REG_VOLUME: begin
        v = data[6:0];
        mix_volume = (v > PCT_SCALE) ? PCT_SCALE : v;
      end
      svbm_pkg::REG_BALANCE: begin
        v = $signed(data);
        if (v > PCT_SCALE) v = PCT_SCALE;
        if (v < -PCT_SCALE) v = -PCT_SCALE;
        mix_balance = v;
      end
      svbm_pkg::REG_MONO: mix_mono = data[0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [svbm_pkg::IDX_W-1:0] idx,
                           input logic [svbm_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    model_write(idx, data);
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every queued frame has gone through and its mix has come back.
  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid || expected_mixes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic signed [15:0] extreme_sample(int k);
    case (k % 6)
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      4:       return 16'sh0001;
      default: return 16'sh8001;
    endcase
  endfunction

  // Mostly full-range samples, with extremes and values near zero mixed in.
  function automatic logic signed [15:0] rand_sample();
    int pick;
    int s;
    logic [31:0] u;
    pick = $urandom_range(0, 9);
    u = $urandom;
    s = int'($urandom_range(0, 200)) - 100;
    if (pick == 0) return extreme_sample($urandom_range(0, 5));
    if (pick == 1) return s[15:0];
    return u[15:0];
  endfunction

  task automatic push_frame(input logic signed [15:0] ls, input logic signed [15:0] rs);
    svbm_pkg::in_frame_t f;
    f.left_sample  = ls;
    f.right_sample = rs;
    pending_frames.push_back(f);
  endtask

  // Register settings for the directed phases; the first keeps the reset values.
  task automatic apply_directed(input int p);
    case (p)
      1: begin
        write_reg(svbm_pkg::REG_VOLUME, 8'd0);
        write_reg(svbm_pkg::REG_BALANCE, 8'd0);
        write_reg(svbm_pkg::REG_MONO, 8'd0);
      end
      2: begin
        write_reg(svbm_pkg::REG_VOLUME, 8'd100);
        write_reg(svbm_pkg::REG_BALANCE, 8'd100);
        write_reg(svbm_pkg::REG_MONO, 8'd0);
      end
      3: write_reg(svbm_pkg::REG_BALANCE, 8'h9c);
      4: begin
        // Volume and balance written above range saturate; mono on.
        write_reg(svbm_pkg::REG_VOLUME, 8'd127);
        write_reg(svbm_pkg::REG_BALANCE, 8'h7f);
        write_reg(svbm_pkg::REG_MONO, 8'd1);
      end
      5: begin
        // Upper data bits of volume are dropped; balance below range saturates.
        write_reg(svbm_pkg::REG_VOLUME, 8'hff);
        write_reg(svbm_pkg::REG_BALANCE, 8'h80);
        write_reg(svbm_pkg::REG_MONO, 8'hff);
      end
      6: begin
        write_reg(svbm_pkg::REG_VOLUME, 8'h81);
        write_reg(svbm_pkg::REG_BALANCE, 8'd1);
        write_reg(svbm_pkg::REG_MONO, 8'h02);
        write_reg(REG_UNUSED, 8'h00);
      end
      7: begin
        write_reg(svbm_pkg::REG_VOLUME, 8'd99);
        write_reg(svbm_pkg::REG_BALANCE, 8'hff);
        write_reg(svbm_pkg::REG_MONO, 8'd0);
        write_reg(REG_UNUSED, 8'haa);
      end
      default: ;
    endcase
  endtask

  function automatic int directed_count(int p);
    case (p)
      0:       return 5;
      1:       return 3;
      2:       return 4;
      3:       return 4;
      4:       return 3;
      5:       return 3;
      default: return 2;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps, some of them empty.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= $urandom_range(1, 48);
      gap_left   <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) expected_mixes.push_back(mix_frame(in_data));
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_frames.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_frames.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a random pattern that changes at random intervals, and
  // each result transfer is checked against the oldest expected mix.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_tick % 7) < 3);
    endcase

    if (rst_n && out_valid && out_ready) begin
      if (expected_mixes.size() == 0) begin
        report_mismatch($sformatf("result transfer %h with no frame outstanding", out_data));
      end else begin
        svbm_pkg::out_frame_t exp_mix;
        exp_mix = expected_mixes.pop_front();
        mixes_checked++;
        if (out_data.left_out !== exp_mix.left_out)
          report_mismatch($sformatf("left_out %h, expected %h",
                                    out_data.left_out, exp_mix.left_out));
        if (out_data.right_out !== exp_mix.right_out)
          report_mismatch($sformatf("right_out %h, expected %h",
                                    out_data.right_out, exp_mix.right_out));
        if (out_data.packed_frame !== exp_mix.packed_frame)
          report_mismatch($sformatf("packed_frame %h, expected %h",
                                    out_data.packed_frame, exp_mix.packed_frame));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed phases first, then random register settings and frames.
  initial begin
    int p;
    int j;
    int b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < DIR_PHASES; p++) begin
      apply_directed(p);
      for (j = 0; j < directed_count(p); j++)
        push_frame(extreme_sample(j + p), extreme_sample(j * 5 + p + 3));
      for (j = 0; j < DIR_RAND; j++)
        push_frame(rand_sample(), rand_sample());
      wait_idle();
      settings_done++;
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      write_reg(svbm_pkg::REG_VOLUME, ($urandom_range(0, 1) != 0) ?
                8'($urandom_range(0, 100)) : 8'($urandom_range(0, 255)));
      b = int'($urandom_range(0, 200)) - 100;
      if ($urandom_range(0, 7) == 0) b = 0;
      write_reg(svbm_pkg::REG_BALANCE, ($urandom_range(0, 2) != 0) ?
                b[7:0] : 8'($urandom_range(0, 255)));
      write_reg(svbm_pkg::REG_MONO, 8'($urandom_range(0, 255)));
      write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
      for (j = 0; j < RAND_ITEMS; j++)
        push_frame(rand_sample(), rand_sample());
      wait_idle();
      settings_done++;
    end

    $display("Checked %0d mixed frames across %0d register settings (%0d register writes),",
             mixes_checked, settings_done, reg_writes);
    $display("covering volume and balance extremes, saturation, mono and ignored writes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
